/* rtl/sbm_pkg.sv */
// ----------------------------------------------------------------------------
// sbm_pkg
// shared types and codes for the sparse byte memory with byte written bits
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

   // operation codes
   localparam logic [1:0] OP_READ_LE   = 2'd0;
   localparam logic [1:0] OP_READ_SWAP = 2'd1;
   localparam logic [1:0] OP_STORE     = 2'd2;
   localparam logic [1:0] OP_ALLOC     = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_MANY  = 2'd1;
   localparam logic [1:0] ST_UNWRITTEN = 2'd2;
   localparam logic [1:0] ST_NO_ROOM   = 2'd3;

   localparam logic [2:0] MAX_BYTES    = 3'd4;
   localparam logic [1:0] TOP_LANE     = 2'd3;
   localparam int         CSR_ADDR_W   = 3;
   localparam logic [31:0] FILL_RESET  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] address;
      logic [2:0]  byte_count;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } rsp_type;

   // sequencer states
   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_LOOK  = 8'b0000_0100,
      S_CMP   = 8'b0000_1000,
      S_RD    = 8'b0001_0000,
      S_CHK   = 8'b0010_0000,
      S_WR    = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

/* rtl/sbm_tag_table.sv */
// ----------------------------------------------------------------------------
// sbm_tag_table
// block tag memory with a single registered read port and the shared comparator
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_tag_table #(
   parameter int TAG_W  = 24,
   parameter int SLOT_W = 6,
   parameter int DEPTH  = 64
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [SLOT_W-1:0] waddr,
   input  wire logic [TAG_W-1:0]  wtag,
   input  wire logic [SLOT_W-1:0] raddr,
   input  wire logic [TAG_W-1:0]  cmp_tag,
   output logic                   hit
);

   logic [TAG_W-1:0] mem [0:DEPTH-1];
   logic [TAG_W-1:0] rtag_ff;

   // tag write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wtag;
      end
      rtag_ff <= mem[raddr];
   end

   // shared tag compare
   assign hit = (rtag_ff == cmp_tag);

endmodule

`default_nettype wire

/* rtl/sbm_byte_ram.sv */
// ----------------------------------------------------------------------------
// sbm_byte_ram
// byte storage with a written bit per byte, cleared by a sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_byte_ram #(
   parameter int ADDR_W = 14,
   parameter int DEPTH  = 16384
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [7:0]        wbyte,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic [7:0]             rbyte,
   output logic                   rwritten,
   output logic                   busy
);

   logic [8:0]        mem [0:DEPTH-1];
   logic [8:0]        rd_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;

   // clearing sweep control
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= 9'd0;
      end else if (we) begin
         mem[waddr] <= {1'b1, wbyte};
      end
      rd_ff <= mem[raddr];
   end

   assign rbyte    = rd_ff[7:0];
   assign rwritten = rd_ff[8];
   assign busy     = busy_ff;

endmodule

`default_nettype wire

/* rtl/sparse_byte_memory_with_valid_bits_unit.sv */
// ----------------------------------------------------------------------------
// sparse_byte_memory_with_valid_bits_unit
// sparse byte memory: tag search over allocated blocks, byte access with written bits
// ----------------------------------------------------------------------------
// sequence: per byte, a tag scan of the allocated blocks in order (S_LOOK then
//   S_CMP per block) until a match, then S_RD and S_CHK for a read byte or S_WR
//   for a stored byte; S_IDLE takes the request and S_DONE returns the response
// throughput: one request at a time; the serial tag scan over one tag port sets the rate
// reset: a sweep over all BLOCK_COUNT*BLOCK_BYTES bytes clears the written bits, during
//   which no request is taken; fill word resets to all ones
`default_nettype none

module sparse_byte_memory_with_valid_bits_unit #(
   parameter int BLOCK_BYTES  = 256,
   parameter int BLOCK_COUNT  = 64,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire sbm_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output sbm_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sbm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int OFS_W  = $clog2(BLOCK_BYTES);
   localparam int TAG_W  = ADDRESS_BITS - OFS_W;
   localparam int SLOT_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);
   localparam int RAM_W  = SLOT_W + OFS_W;
   localparam int DEPTH  = BLOCK_COUNT * BLOCK_BYTES;

   sbm_pkg::state_type state_ff, state_in;
   logic [31:0]             fill_ff;
   logic [1:0]              op_ff, op_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [31:0]             wdata_ff, wdata_in;
   logic [2:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [31:0]             word_ff, word_in;
   logic [1:0]              stat_ff, stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sbm_pkg::rsp_type        rsp_ff, rsp_in;

   logic [ADDRESS_BITS-1:0] cur_addr;
   logic [TAG_W-1:0]        cur_tag;
   logic [OFS_W-1:0]        cur_ofs;
   logic                    tag_we, tag_hit;
   logic                    ram_we, ram_written, ram_busy;
   logic [7:0]              ram_rbyte, store_byte;
   logic [1:0]              lane;
   logic                    is_read, req_take, csr_write;

   // current byte address wraps at the address width
   assign cur_addr   = addr_ff + ADDRESS_BITS'(idx_ff);
   assign cur_tag    = cur_addr[ADDRESS_BITS-1:OFS_W];
   assign cur_ofs    = cur_addr[OFS_W-1:0];
   assign is_read    = (op_ff == sbm_pkg::OP_READ_LE) || (op_ff == sbm_pkg::OP_READ_SWAP);
   assign store_byte = wdata_ff[{idx_ff[1:0], 3'b000} +: 8];
   assign lane       = (op_ff == sbm_pkg::OP_READ_LE) ? idx_ff[1:0]
                                                      : sbm_pkg::TOP_LANE - idx_ff[1:0];
   assign req_take   = req_valid && !req_stall;

   sbm_tag_table #(
      .TAG_W  (TAG_W),
      .SLOT_W (SLOT_W),
      .DEPTH  (BLOCK_COUNT)
   ) u_tags (
      .clock   (clock),
      .we      (tag_we),
      .waddr   (used_ff[SLOT_W-1:0]),
      .wtag    (cur_tag),
      .raddr   (scan_ff[SLOT_W-1:0]),
      .cmp_tag (cur_tag),
      .hit     (tag_hit)
   );

   sbm_byte_ram #(
      .ADDR_W (RAM_W),
      .DEPTH  (DEPTH)
   ) u_bytes (
      .clock    (clock),
      .reset    (reset),
      .we       (ram_we),
      .waddr    ({slot_ff, cur_ofs}),
      .wbyte    (store_byte),
      .raddr    ({slot_ff, cur_ofs}),
      .rbyte    (ram_rbyte),
      .rwritten (ram_written),
      .busy     (ram_busy)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      wdata_in     = wdata_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      used_in      = used_ff;
      slot_in      = slot_ff;
      word_in      = word_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      tag_we       = 1'b0;
      ram_we       = 1'b0;
      unique case (state_ff) inside
         sbm_pkg::S_CLEAR: begin
            if (!ram_busy) begin
               state_in = sbm_pkg::S_IDLE;
            end
         end
         sbm_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               addr_in  = req_data.address[ADDRESS_BITS-1:0];
               cnt_in   = req_data.byte_count;
               wdata_in = (req_data.op == sbm_pkg::OP_ALLOC) ? fill_ff : req_data.write_data;
               idx_in   = '0;
               scan_in  = '0;
               word_in  = '0;
               stat_in  = sbm_pkg::ST_OK;
               if (req_data.byte_count > sbm_pkg::MAX_BYTES) begin
                  stat_in  = sbm_pkg::ST_TOO_MANY;
                  state_in = sbm_pkg::S_DONE;
               end else if (req_data.byte_count == 3'd0) begin
                  state_in = sbm_pkg::S_DONE;
               end else begin
                  state_in = sbm_pkg::S_LOOK;
               end
            end
         end
         sbm_pkg::S_LOOK, sbm_pkg::S_CMP: begin
            if ((state_ff == sbm_pkg::S_CMP) && tag_hit) begin
               slot_in  = scan_ff[SLOT_W-1:0];
               state_in = is_read ? sbm_pkg::S_RD : sbm_pkg::S_WR;
            end else if ((state_ff == sbm_pkg::S_LOOK) && (used_ff != '0)) begin
               state_in = sbm_pkg::S_CMP;
            end else if ((state_ff == sbm_pkg::S_CMP) && ((scan_ff + 1'b1) < used_ff)) begin
               scan_in  = scan_ff + 1'b1;
               state_in = sbm_pkg::S_LOOK;
            end else if (is_read) begin
               // block missing
               stat_in  = sbm_pkg::ST_UNWRITTEN;
               state_in = sbm_pkg::S_DONE;
            end else if (used_ff == CNT_W'(BLOCK_COUNT)) begin
               stat_in  = sbm_pkg::ST_NO_ROOM;
               state_in = sbm_pkg::S_DONE;
            end else begin
               // allocate the next block in order
               tag_we   = 1'b1;
               slot_in  = used_ff[SLOT_W-1:0];
               used_in  = used_ff + 1'b1;
               state_in = sbm_pkg::S_WR;
            end
         end
         sbm_pkg::S_RD: begin
            state_in = sbm_pkg::S_CHK;
         end
         sbm_pkg::S_CHK: begin
            if (!ram_written) begin
               stat_in  = sbm_pkg::ST_UNWRITTEN;
               state_in = sbm_pkg::S_DONE;
            end else begin
               word_in[{lane, 3'b000} +: 8] = ram_rbyte;
               idx_in  = idx_ff + 1'b1;
               scan_in = '0;
               state_in = ((idx_ff + 1'b1) == cnt_ff) ? sbm_pkg::S_DONE : sbm_pkg::S_LOOK;
            end
         end
         sbm_pkg::S_WR: begin
            ram_we  = 1'b1;
            idx_in  = idx_ff + 1'b1;
            scan_in = '0;
            state_in = ((idx_ff + 1'b1) == cnt_ff) ? sbm_pkg::S_DONE : sbm_pkg::S_LOOK;
         end
         sbm_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = stat_ff;
               if (!is_read) begin
                  rsp_in.read_data = '0;
               end else if (stat_ff == sbm_pkg::ST_OK) begin
                  rsp_in.read_data = word_ff;
               end else begin
                  rsp_in.read_data = fill_ff;
               end
               state_in = sbm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbm_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbm_pkg::S_CLEAR;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= sbm_pkg::FILL_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            fill_ff <= csr_pwdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      wdata_ff <= wdata_in;
      idx_ff   <= idx_in;
      scan_ff  <= scan_in;
      slot_ff  <= slot_in;
      word_ff  <= word_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? fill_ff : 32'd0;
   assign csr_pready = 1'b1;

   assign req_stall = (state_ff != sbm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // allocation count never passes the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(BLOCK_COUNT))
      else $error("block count beyond table size");

   // blocks are only allocated by stores and allocates
   a_alloc_store: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> !is_read)
      else $error("block allocated by a read");

   // an accepted request always leaves idle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != sbm_pkg::S_IDLE))
      else $error("sequencer stayed idle after a request");

   // no byte access during the clearing sweep
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> (!ram_we && !req_take))
      else $error("access during clearing sweep");

endmodule

`default_nettype wire
